// ----- sv/bsa_pkg.sv -----
// Shared types and constants of the bitmap slot allocator.
// No dependencies; the allocator core reads these by scoped name.
`default_nettype none

package bsa_pkg;

  localparam int MAX_SLOTS_DEF = 512;
  localparam int WORD_BITS_DEF = 64;

  localparam int EC_W     = 10;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 2;

  localparam logic [EC_W-1:0] EC_RESET = 10'd512;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- sv/bitmap_slot_allocator_core.sv -----
// Bitmap slot allocator: used bits in a RAM, read-modify-write sequencer.
// Depends on bsa_pkg, bsa_ram and bsa_ffz. One request at a time: a rejected request goes
// straight to the response; an allocate reads the hinted word, or scans the bitmap word
// by word (also after a stale hint); a free divides, reads the word, then clears the bit.
// The result is loaded as the sequencer returns to idle; a stalled result holds the sequencer.
// Reset and config writes clear one RAM word per cycle (8 by default); input held off.
`default_nettype none

module bitmap_slot_allocator_core #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_opcode,
  input  wire logic [bsa_pkg::SLOT_W-1:0]   in_slot_index,
  input  wire logic                         in_only_in_pool,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bsa_pkg::STATUS_W-1:0] out_status,
  output logic      [bsa_pkg::SLOT_W-1:0]   out_granted_slot,
  output logic                              out_left_pool,
  output logic                              out_rejoined_pool,
  output logic                              out_keep_page,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bsa_pkg::EC_W-1:0]     cfg_element_count
);

  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int BASE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);
  localparam int SW         = bsa_pkg::SLOT_W;
  localparam int DIV_K      = SW + BW;
  localparam int RECIP      = (2 ** DIV_K + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W     = SW + DIV_K;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RESP  = 7'b0000100,
    S_HINT  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FREE  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      free_count_r, free_count_nxt;
  logic                  page_alive_r, page_alive_nxt;
  logic                  hint_valid_r, hint_valid_nxt;
  logic [SW-1:0]         hint_slot_r, hint_slot_nxt;
  logic [AW-1:0]         hint_word_r, hint_word_nxt;
  logic [BW-1:0]         hint_bit_r, hint_bit_nxt;
  logic                  op_r, op_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic                  only_r, only_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [AW-1:0]         free_word_r, free_word_nxt;
  logic [BW-1:0]         free_bit_r, free_bit_nxt;
  logic [AW-1:0]         scan_addr_r, scan_addr_nxt;
  logic [BASE_W-1:0]     scan_base_r, scan_base_nxt;

  logic                  out_valid_r, out_valid_nxt;
  bsa_pkg::status_t      status_r, status_nxt;
  logic [SW-1:0]         granted_r, granted_nxt;
  logic                  left_r, left_nxt;
  logic                  rejoin_r, rejoin_nxt;
  logic                  keep_r, keep_nxt;

  logic                  ram_wr_en, ram_rd_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [WORD_BITS-1:0]  ram_wr_data, ram_rd_data;

  logic [WORD_BITS-1:0]  scan_mask;
  logic [CNT_W-1:0]      scan_rem;
  logic                  ffz_found;
  logic [BW-1:0]         ffz_idx;

  logic                  out_free;
  logic                  alloc_grant;
  logic                  hint_ok;
  logic                  slot_lt_total;
  logic                  scan_more;
  logic                  was_full;
  logic                  retire;
  logic [CNT_W-1:0]      fc_inc;
  logic [CNT_W-1:0]      cfg_total;
  logic [PROD_W-1:0]     div_q;

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign scan_rem = total_r - CNT_W'(scan_base_r);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_mask[b] = 32'(b) < 32'(scan_rem);
    end
  end

  bsa_ffz #(
    .WIDTH (WORD_BITS)
  ) u_ffz (
    .avail (~ram_rd_data & scan_mask),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  assign out_free      = !out_valid_r || out_ready;
  assign hint_ok       = hint_valid_r && (32'(hint_slot_r) < 32'(total_r));
  assign slot_lt_total = 32'(in_slot_index) < 32'(total_r);
  assign scan_more     = (32'(scan_base_r) + 32'(WORD_BITS)) < 32'(total_r);
  assign was_full      = free_count_r == '0;
  assign fc_inc        = free_count_r + CNT_W'(1);
  assign retire        = !(was_full && (32'(total_r) > 32'd1)) && (fc_inc == total_r)
                         && !only_r;
  assign div_q         = prod_r >> DIV_K;
  assign cfg_total     = (32'(cfg_element_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                   : CNT_W'(cfg_element_count);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    total_nxt      = total_r;
    free_count_nxt = free_count_r;
    page_alive_nxt = page_alive_r;
    hint_valid_nxt = hint_valid_r;
    hint_slot_nxt  = hint_slot_r;
    hint_word_nxt  = hint_word_r;
    hint_bit_nxt   = hint_bit_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    only_nxt       = only_r;
    prod_nxt       = prod_r;
    free_word_nxt  = free_word_r;
    free_bit_nxt   = free_bit_r;
    scan_addr_nxt  = scan_addr_r;
    scan_base_nxt  = scan_base_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    left_nxt       = left_r;
    rejoin_nxt     = rejoin_r;
    keep_nxt       = keep_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = '0;
    alloc_grant    = 1'b0;
    in_ready       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_r;
        if (clr_addr_r == AW'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = !cfg_valid;
        if (in_valid && in_ready) begin
          op_nxt   = in_opcode;
          slot_nxt = in_slot_index;
          only_nxt = in_only_in_pool;
          if (in_opcode == bsa_pkg::OP_ALLOC) begin
            if (free_count_r == '0 || !page_alive_r || total_r == '0) begin
              state_nxt = S_RESP;
            end else if (hint_ok) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = hint_word_r;
              state_nxt   = S_HINT;
            end else begin
              ram_rd_en     = 1'b1;
              scan_addr_nxt = '0;
              scan_base_nxt = '0;
              state_nxt     = S_SCAN;
            end
          end else if (total_r == '0 || !slot_lt_total) begin
            state_nxt = S_RESP;
          end else begin
            prod_nxt  = PROD_W'(in_slot_index) * PROD_W'(RECIP);
            state_nxt = S_DIV;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          left_nxt      = 1'b0;
          rejoin_nxt    = 1'b0;
          if (op_r == bsa_pkg::OP_ALLOC) begin
            status_nxt = bsa_pkg::ST_NONE;
            keep_nxt   = page_alive_r;
          end else if (total_r == '0) begin
            status_nxt = bsa_pkg::ST_OK;
            keep_nxt   = 1'b1;
          end else begin
            status_nxt = bsa_pkg::ST_NOT_ALLOC;
            keep_nxt   = page_alive_r;
          end
          state_nxt = S_IDLE;
        end
      end
      S_HINT: begin
        if (ram_rd_data[hint_bit_r]) begin
          ram_rd_en     = 1'b1;
          scan_addr_nxt = '0;
          scan_base_nxt = '0;
          state_nxt     = S_SCAN;
        end else if (out_free) begin
          alloc_grant    = 1'b1;
          ram_wr_en      = 1'b1;
          ram_wr_addr    = hint_word_r;
          ram_wr_data    = ram_rd_data | (WORD_BITS'(1) << hint_bit_r);
          free_count_nxt = free_count_r - CNT_W'(1);
          hint_valid_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          status_nxt     = bsa_pkg::ST_OK;
          granted_nxt    = hint_slot_r;
          left_nxt       = free_count_r == CNT_W'(1);
          rejoin_nxt     = 1'b0;
          keep_nxt       = page_alive_r;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ffz_found) begin
          if (out_free) begin
            alloc_grant    = 1'b1;
            ram_wr_en      = 1'b1;
            ram_wr_addr    = scan_addr_r;
            ram_wr_data    = ram_rd_data | (WORD_BITS'(1) << ffz_idx);
            free_count_nxt = free_count_r - CNT_W'(1);
            hint_valid_nxt = 1'b0;
            out_valid_nxt  = 1'b1;
            status_nxt     = bsa_pkg::ST_OK;
            granted_nxt    = SW'(32'(scan_base_r) + 32'(ffz_idx));
            left_nxt       = free_count_r == CNT_W'(1);
            rejoin_nxt     = 1'b0;
            keep_nxt       = page_alive_r;
            state_nxt      = S_IDLE;
          end
        end else if (scan_more) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = scan_addr_r + AW'(1);
          scan_addr_nxt = scan_addr_r + AW'(1);
          scan_base_nxt = scan_base_r + BASE_W'(WORD_BITS);
        end else if (out_free) begin
          hint_valid_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          status_nxt     = bsa_pkg::ST_NONE;
          granted_nxt    = '0;
          left_nxt       = 1'b0;
          rejoin_nxt     = 1'b0;
          keep_nxt       = page_alive_r;
          state_nxt      = S_IDLE;
        end
      end
      S_DIV: begin
        free_word_nxt = AW'(div_q);
        free_bit_nxt  = BW'(32'(slot_r) - 32'(div_q) * 32'(WORD_BITS));
        ram_rd_en     = 1'b1;
        ram_rd_addr   = AW'(div_q);
        state_nxt     = S_FREE;
      end
      S_FREE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          if (ram_rd_data[free_bit_r]) begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = free_word_r;
            ram_wr_data    = ram_rd_data & ~(WORD_BITS'(1) << free_bit_r);
            hint_valid_nxt = 1'b1;
            hint_slot_nxt  = slot_r;
            hint_word_nxt  = free_word_r;
            hint_bit_nxt   = free_bit_r;
            free_count_nxt = fc_inc;
            status_nxt     = bsa_pkg::ST_OK;
            rejoin_nxt     = was_full;
            left_nxt       = retire;
            keep_nxt       = !retire;
            if (retire) begin
              page_alive_nxt = 1'b0;
            end
          end else begin
            status_nxt = bsa_pkg::ST_NOT_ALLOC;
            left_nxt   = 1'b0;
            rejoin_nxt = 1'b0;
            keep_nxt   = page_alive_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // restart the page on a config write
    if (cfg_valid) begin
      total_nxt      = cfg_total;
      free_count_nxt = cfg_total;
      page_alive_nxt = 1'b1;
      hint_valid_nxt = 1'b1;
      hint_slot_nxt  = '0;
      hint_word_nxt  = '0;
      hint_bit_nxt   = '0;
      clr_addr_nxt   = '0;
      state_nxt      = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      total_r      <= (32'(bsa_pkg::EC_RESET) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(bsa_pkg::EC_RESET);
      free_count_r <= (32'(bsa_pkg::EC_RESET) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(bsa_pkg::EC_RESET);
      page_alive_r <= 1'b1;
      hint_valid_r <= 1'b1;
      hint_slot_r  <= '0;
      hint_word_r  <= '0;
      hint_bit_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      total_r      <= total_nxt;
      free_count_r <= free_count_nxt;
      page_alive_r <= page_alive_nxt;
      hint_valid_r <= hint_valid_nxt;
      hint_slot_r  <= hint_slot_nxt;
      hint_word_r  <= hint_word_nxt;
      hint_bit_r   <= hint_bit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    slot_r      <= slot_nxt;
    only_r      <= only_nxt;
    prod_r      <= prod_nxt;
    free_word_r <= free_word_nxt;
    free_bit_r  <= free_bit_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_base_r <= scan_base_nxt;
    status_r    <= status_nxt;
    granted_r   <= granted_nxt;
    left_r      <= left_nxt;
    rejoin_r    <= rejoin_nxt;
    keep_r      <= keep_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_slot  = granted_r;
  assign out_left_pool     = left_r;
  assign out_rejoined_pool = rejoin_r;
  assign out_keep_page     = keep_r;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= total_r)
    else $error("free count above slot count");

  a_retired_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !page_alive_r |-> free_count_r == total_r)
    else $error("retired page holds used slots");

  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    (alloc_grant && !cfg_valid) |=> free_count_r == $past(free_count_r) - CNT_W'(1))
    else $error("grant did not consume a free slot");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !ram_rd_en && !in_ready)
    else $error("request or read during clearing pass");

endmodule

`default_nettype wire

// ----- sv/bsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                    wr_data,
  input  wire logic                                rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/bsa_ffz.sv -----
// Lowest-set-bit search over one bitmap word of available slots.
// No dependencies.
`default_nettype none

module bsa_ffz #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]         avail,
  output logic                          found,
  output logic [$clog2(WIDTH)-1:0]      idx
);

  localparam int IDX_W = $clog2(WIDTH);

  logic [WIDTH-1:0] lowest;

  assign lowest = avail & (~avail + WIDTH'(1));
  assign found  = |avail;

  always_comb begin
    idx = '0;
    for (int b = 0; b < WIDTH; b++) begin
      if (lowest[b]) begin
        idx = idx | IDX_W'(b);
      end
    end
  end

endmodule

`default_nettype wire
